FILE: hw/rtl/motor_drive_output_stage_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the motor drive output stage
// Concurrent checks sampled on clk, switched off while rst is high.
// ----------------------------------------------------------------------------
`ifndef MOTOR_DRIVE_OUTPUT_STAGE_CORE_MACROS_SVH
`define MOTOR_DRIVE_OUTPUT_STAGE_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MDOS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MDOS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/mdos_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdos_pkg
// Shared types and constants for the motor drive output stage.
// ----------------------------------------------------------------------------
package mdos_pkg;

  // Working width of a mixed drive: brake product needs 26 bits plus negation.
  localparam int DRIVE_W = 27;
  // Width for slew arithmetic (drive minus previous drive).
  localparam int WIDE_W  = 28;
  localparam int PREV_W  = 15;
  localparam int DUTY_W  = 14;
  localparam int GAIN_W  = 8;
  localparam int LIMIT_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE_GAIN       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLEW_STEP        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_MAX         = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_WHEEL_LIMIT = 2'd3;

  // Reset values
  localparam logic [GAIN_W-1:0]         BRAKE_GAIN_RST       = 8'd30;
  localparam logic [DUTY_W-1:0]         SLEW_STEP_RST        = 14'd5000;
  localparam logic [DUTY_W-1:0]         DUTY_MAX_RST         = 14'd9999;
  localparam logic signed [LIMIT_W-1:0] FAST_WHEEL_LIMIT_RST = 16'sd100;

  // Protect mode codes
  localparam logic [1:0] MODE_BALANCE_ONLY = 2'd2;
  localparam logic [1:0] MODE_STEER_ONLY   = 2'd3;

  typedef logic signed [DRIVE_W-1:0] drive_t;
  typedef logic signed [WIDE_W-1:0]  wide_t;
  typedef logic signed [PREV_W-1:0]  prev_t;
  typedef logic [DUTY_W-1:0]         duty_t;

  // Shaping controls shared by both wheel shapers
  typedef struct packed {
    logic  slew_en;
    duty_t slew_step;
    duty_t duty_max;
  } shape_ctrl_t;

endpackage

FILE: hw/rtl/mdos_mix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdos_mix
// Wheel drive mixing (brake, protect modes, normal) and ramp quartering.
// ----------------------------------------------------------------------------
module mdos_mix
  import mdos_pkg::*;
(
  input  logic signed [16:0]        balance_drive,
  input  logic signed [13:0]        steer_drive,
  input  logic                      stop_request,
  input  logic [1:0]                protect_mode,
  input  logic                      ramp_section,
  input  logic signed [15:0]        left_count,
  input  logic signed [15:0]        right_count,
  input  logic signed [16:0]        speed_sum,
  input  logic [GAIN_W-1:0]         brake_gain,
  input  logic signed [LIMIT_W-1:0] fast_wheel_limit,
  output drive_t                    left_mixed,
  output drive_t                    right_mixed
);

  // Divide by four, truncating toward zero: bias negatives by three first.
  function automatic drive_t quarter(input drive_t d);
    drive_t bias;
    bias = drive_t'({d[DRIVE_W-1], d[DRIVE_W-1]});
    return (d + bias) >>> 2;
  endfunction

  logic signed [25:0] brake_prod;
  drive_t brake;
  drive_t bal;
  drive_t steer;
  drive_t left_raw;
  drive_t right_raw;

  assign brake_prod = speed_sum * $signed({1'b0, brake_gain});
  assign brake      = -drive_t'(brake_prod);
  assign bal        = drive_t'(balance_drive);
  assign steer      = drive_t'(steer_drive);

  always_comb begin
    if (stop_request) begin
      left_raw  = brake;
      right_raw = brake;
    end else if (protect_mode == MODE_BALANCE_ONLY) begin
      left_raw  = bal;
      right_raw = bal;
    end else if (protect_mode == MODE_STEER_ONLY) begin
      left_raw  = -steer;
      right_raw = steer;
    end else begin
      left_raw  = bal - steer;
      right_raw = bal + steer;
    end
  end

  assign left_mixed  = (ramp_section && (left_count > fast_wheel_limit)) ?
                       quarter(left_raw) : left_raw;
  assign right_mixed = (ramp_section && (right_count > fast_wheel_limit)) ?
                       quarter(right_raw) : right_raw;

endmodule

FILE: hw/rtl/mdos_shape.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdos_shape
// Per-wheel slew limit, saturation and H-bridge duty split.
// ----------------------------------------------------------------------------
module mdos_shape
  import mdos_pkg::*;
(
  input  drive_t      drive,
  input  prev_t       prev,
  input  shape_ctrl_t ctrl,
  output prev_t       shaped,
  output duty_t       forward_duty,
  output duty_t       reverse_duty
);

  wide_t d;
  wide_t p;
  wide_t step;
  wide_t lim;
  wide_t diff;
  wide_t slewed;
  wide_t clamped;
  wide_t neg;

  assign d    = wide_t'(drive);
  assign p    = wide_t'(prev);
  assign step = wide_t'({1'b0, ctrl.slew_step});
  assign lim  = wide_t'({1'b0, ctrl.duty_max});
  assign diff = d - p;

  always_comb begin
    slewed = d;
    if (ctrl.slew_en) begin
      if (diff > step) begin
        slewed = p + step;
      end else if (diff < -step) begin
        slewed = p - step;
      end
    end
    clamped = slewed;
    if (slewed > lim) begin
      clamped = lim;
    end else if (slewed < -lim) begin
      clamped = -lim;
    end
  end

  assign neg          = -clamped;
  assign shaped       = clamped[PREV_W-1:0];
  assign forward_duty = (clamped > 0) ? clamped[DUTY_W-1:0] : '0;
  assign reverse_duty = (clamped < 0) ? neg[DUTY_W-1:0] : '0;

endmodule

FILE: hw/rtl/motor_drive_output_stage_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_drive_output_stage_core
// Mixes balance and steering drives into two H-bridge duty pairs per tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one control word per tick: drives,
//   mode flags, encoder counts and speed sum. Output channel
//   (out_valid/out_ready) gives the four duties for that word.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   brake_gain, slew_step, duty_max, fast_wheel_limit; cfg_ready is always
//   high. Write config only while no word is in flight.
// Path: input register, then mixing and shaping logic into the result
//   register; out_valid rises when the word moves on into that register.
// Throughput: one word per cycle while out_ready is high; the previous-drive
//   registers update with the result register, so the next word sees them.
// Stall: when out_ready is low the result register holds; the input register
//   can still take one more word, after which in_ready drops.
// Reset: empties both stages, clears previous drives to zero and loads the
//   register defaults (gain 30, step 5000, duty max 9999, limit 100).
// ----------------------------------------------------------------------------
module motor_drive_output_stage_core
  import mdos_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // input words
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [16:0]    balance_drive,
  input  logic signed [13:0]    steer_drive,
  input  logic                  stop_request,
  input  logic [1:0]            protect_mode,
  input  logic                  ramp_section,
  input  logic                  special_section,
  input  logic signed [15:0]    left_count,
  input  logic signed [15:0]    right_count,
  input  logic signed [16:0]    speed_sum,
  // result words
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [13:0]           left_forward_duty,
  output logic [13:0]           left_reverse_duty,
  output logic [13:0]           right_forward_duty,
  output logic [13:0]           right_reverse_duty,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  `include "motor_drive_output_stage_core_macros.svh"

  // Config registers
  logic [GAIN_W-1:0]         brake_gain;
  duty_t                     slew_step;
  duty_t                     duty_max;
  logic signed [LIMIT_W-1:0] fast_wheel_limit;

  // Input register
  logic                in_full;
  logic signed [16:0]  bal_q;
  logic signed [13:0]  steer_q;
  logic                stop_q;
  logic [1:0]          mode_q;
  logic                ramp_q;
  logic                special_q;
  logic signed [15:0]  lc_q;
  logic signed [15:0]  rc_q;
  logic signed [16:0]  sum_q;

  // Drive history
  prev_t prev_left;
  prev_t prev_right;

  logic advance;
  logic in_take;

  drive_t      left_mixed;
  drive_t      right_mixed;
  shape_ctrl_t ctrl;
  prev_t       left_next;
  prev_t       right_next;
  duty_t       lf_next;
  duty_t       lr_next;
  duty_t       rf_next;
  duty_t       rr_next;

  // Word in the input register moves on when the result slot is free or emptying
  assign advance   = in_full && (!out_valid || out_ready);
  assign in_ready  = !in_full || advance;
  assign in_take   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      brake_gain       <= BRAKE_GAIN_RST;
      slew_step        <= SLEW_STEP_RST;
      duty_max         <= DUTY_MAX_RST;
      fast_wheel_limit <= FAST_WHEEL_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BRAKE_GAIN:       brake_gain       <= cfg_data[GAIN_W-1:0];
        REG_SLEW_STEP:        slew_step        <= cfg_data[DUTY_W-1:0];
        REG_DUTY_MAX:         duty_max         <= cfg_data[DUTY_W-1:0];
        REG_FAST_WHEEL_LIMIT: fast_wheel_limit <= $signed(cfg_data[LIMIT_W-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      bal_q     <= balance_drive;
      steer_q   <= steer_drive;
      stop_q    <= stop_request;
      mode_q    <= protect_mode;
      ramp_q    <= ramp_section;
      special_q <= special_section;
      lc_q      <= left_count;
      rc_q      <= right_count;
      sum_q     <= speed_sum;
    end
  end

  mdos_mix u_mix (
    .balance_drive    (bal_q),
    .steer_drive      (steer_q),
    .stop_request     (stop_q),
    .protect_mode     (mode_q),
    .ramp_section     (ramp_q),
    .left_count       (lc_q),
    .right_count      (rc_q),
    .speed_sum        (sum_q),
    .brake_gain       (brake_gain),
    .fast_wheel_limit (fast_wheel_limit),
    .left_mixed       (left_mixed),
    .right_mixed      (right_mixed)
  );

  assign ctrl.slew_en   = ramp_q || special_q;
  assign ctrl.slew_step = slew_step;
  assign ctrl.duty_max  = duty_max;

  mdos_shape u_shape_left (
    .drive        (left_mixed),
    .prev         (prev_left),
    .ctrl         (ctrl),
    .shaped       (left_next),
    .forward_duty (lf_next),
    .reverse_duty (lr_next)
  );

  mdos_shape u_shape_right (
    .drive        (right_mixed),
    .prev         (prev_right),
    .ctrl         (ctrl),
    .shaped       (right_next),
    .forward_duty (rf_next),
    .reverse_duty (rr_next)
  );

  // History follows the word into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_left  <= '0;
      prev_right <= '0;
    end else if (advance) begin
      prev_left  <= left_next;
      prev_right <= right_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      left_forward_duty  <= lf_next;
      left_reverse_duty  <= lr_next;
      right_forward_duty <= rf_next;
      right_reverse_duty <= rr_next;
    end
  end

  // Checks
  `MDOS_ASSERT_SAME(a_left_one_side, out_valid,
    (left_forward_duty == '0) || (left_reverse_duty == '0),
    "left duties both active")
  `MDOS_ASSERT_SAME(a_duty_bound, out_valid,
    (left_forward_duty <= duty_max) && (left_reverse_duty <= duty_max) &&
    (right_forward_duty <= duty_max) && (right_reverse_duty <= duty_max),
    "duty beyond duty_max")
  `MDOS_ASSERT_SAME(a_ready_only_when_blocked, !in_ready,
    in_full && out_valid && !out_ready,
    "input stalled without back-pressure")
  `MDOS_ASSERT_NEXT(a_history_holds, !advance,
    $stable(prev_left) && $stable(prev_right),
    "drive history moved without a word")

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for motor_drive_output_stage_core. Tick words go in
// through the valid/ready input channel and a predictor works out the four
// duties that each word must produce. Every duty word that comes out is
// checked against the oldest prediction. The run covers the register
// extremes on the config channel and random stalls on both channels.
// ----------------------------------------------------------------------------
module tb
  import mdos_pkg::*;
();

  localparam int CLK_PERIOD       = 20;
  localparam int RESET_CYCLES     = 12;
  localparam int MAX_GAP          = 7;
  localparam int RANDOM_PER_PHASE = 110;
  // phase 0 runs on reset defaults, phases 1..7 each load new settings
  localparam int NUM_PHASES       = 8;
  // pipeline is two deep, so this quiet stretch is plenty
  localparam int SETTLE_CYCLES    = 4;
  // worst quiet stretch is a sender gap plus a receiver stall plus latency,
  // so this bound has a wide margin
  localparam int WATCHDOG_LIMIT   = 1000;
  localparam int MAX_SHOWN        = 10;

  localparam int BAL_MAX   = 65535;
  localparam int BAL_MIN   = -65536;
  localparam int STEER_MAX = 8191;
  localparam int STEER_MIN = -8192;
  localparam int COUNT_MAX = 32767;
  localparam int COUNT_MIN = -32768;

  // protect modes 0 and 1 both give normal mixing
  localparam logic [1:0] MODE_NORMAL     = 2'd0;
  localparam logic [1:0] MODE_NORMAL_ALT = 2'd1;

  typedef struct {
    logic signed [16:0] balance;
    logic signed [13:0] steer;
    logic               stop;
    logic [1:0]         mode;
    logic               ramp;
    logic               special;
    logic signed [15:0] lcount;
    logic signed [15:0] rcount;
    logic signed [16:0] sum;
  } tick_word_t;

  typedef struct packed {
    duty_t lf;
    duty_t lr;
    duty_t rf;
    duty_t rr;
  } duty_word_t;

  // --------------------------------------------------------------------------
  // Duty predictor and scoreboard: own copy of the registers and of the
  // previous drives, a queue of predicted duty words.
  // --------------------------------------------------------------------------
  class duty_predictor;
    logic [GAIN_W-1:0]         brake_gain;
    duty_t                     slew_step;
    duty_t                     duty_max;
    logic signed [LIMIT_W-1:0] fast_limit;
    prev_t                     prev_left;
    prev_t                     prev_right;
    duty_word_t                expected_duties[$];
    int                        words_noted;
    int                        results_checked;
    int                        errors;
    int                        shown;

    function new();
      brake_gain      = BRAKE_GAIN_RST;
      slew_step       = SLEW_STEP_RST;
      duty_max        = DUTY_MAX_RST;
      fast_limit      = FAST_WHEEL_LIMIT_RST;
      prev_left       = '0;
      prev_right      = '0;
      words_noted     = 0;
      results_checked = 0;
      errors          = 0;
      shown           = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_BRAKE_GAIN:       brake_gain = data[GAIN_W-1:0];
        REG_SLEW_STEP:        slew_step  = data[DUTY_W-1:0];
        REG_DUTY_MAX:         duty_max   = data[DUTY_W-1:0];
        REG_FAST_WHEEL_LIMIT: fast_limit = data;
        default: ;
      endcase
    endfunction

    // slew clamp against the last drive, then saturation at +/- duty_max
    function longint shape_drive(longint d, prev_t prev, bit slew);
      longint p;
      longint step;
      longint lim;
      p    = longint'(prev);
      step = longint'(slew_step);
      lim  = longint'(duty_max);
      if (slew) begin
        if (d - p > step) d = p + step;
        if (d - p < -step) d = p - step;
      end
      if (d > lim) d = lim;
      if (d < -lim) d = -lim;
      return d;
    endfunction

    function void note_word(tick_word_t w);
      longint     l;
      longint     r;
      longint     sum;
      longint     gain;
      longint     lc;
      longint     rc;
      longint     lim;
      bit         slew;
      duty_word_t e;
      sum  = longint'(w.sum);
      gain = longint'(brake_gain);
      lc   = longint'(w.lcount);
      rc   = longint'(w.rcount);
      lim  = longint'(fast_limit);
      slew = w.ramp || w.special;
      if (w.stop) begin
        l = -(sum * gain);
        r = l;
      end else if (w.mode == MODE_BALANCE_ONLY) begin
        l = longint'(w.balance);
        r = longint'(w.balance);
      end else if (w.mode == MODE_STEER_ONLY) begin
        l = -longint'(w.steer);
        r = longint'(w.steer);
      end else begin
        l = longint'(w.balance) - longint'(w.steer);
        r = longint'(w.balance) + longint'(w.steer);
      end
      // division truncates toward zero, as the quartering needs
      if (w.ramp && lc > lim) l = l / 4;
      if (w.ramp && rc > lim) r = r / 4;
      l = shape_drive(l, prev_left, slew);
      r = shape_drive(r, prev_right, slew);
      prev_left  = prev_t'(l);
      prev_right = prev_t'(r);
      e.lf = (l > 0) ? duty_t'(l) : '0;
      e.lr = (l < 0) ? duty_t'(-l) : '0;
      e.rf = (r > 0) ? duty_t'(r) : '0;
      e.rr = (r < 0) ? duty_t'(-r) : '0;
      expected_duties.push_back(e);
      words_noted++;
    endfunction

    function void check_duties(duty_word_t got);
      duty_word_t e;
      results_checked++;
      if (expected_duties.size() == 0) begin
        errors++;
        if (shown < MAX_SHOWN) begin
          shown++;
          $display("unexpected duty word lf=%0d lr=%0d rf=%0d rr=%0d",
                   got.lf, got.lr, got.rf, got.rr);
        end
        return;
      end
      e = expected_duties.pop_front();
      if (got.lf != e.lf || got.lr != e.lr || got.rf != e.rf || got.rr != e.rr) begin
        errors++;
        if (shown < MAX_SHOWN) begin
          shown++;
          $display("duty mismatch: expected lf=%0d lr=%0d rf=%0d rr=%0d",
                   e.lf, e.lr, e.rf, e.rr);
          $display("               got      lf=%0d lr=%0d rf=%0d rr=%0d",
                   got.lf, got.lr, got.rf, got.rr);
        end
      end
    endfunction

    function int pending();
      return expected_duties.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT signals and instance
  // --------------------------------------------------------------------------
  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic signed [16:0]    balance_drive;
  logic signed [13:0]    steer_drive;
  logic                  stop_request;
  logic [1:0]            protect_mode;
  logic                  ramp_section;
  logic                  special_section;
  logic signed [15:0]    left_count;
  logic signed [15:0]    right_count;
  logic signed [16:0]    speed_sum;
  logic                  out_valid;
  logic                  out_ready;
  logic [13:0]           left_forward_duty;
  logic [13:0]           left_reverse_duty;
  logic [13:0]           right_forward_duty;
  logic [13:0]           right_reverse_duty;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  duty_predictor model = new();

  // idling switches, changed per phase so some stretches run flat out
  bit in_gaps_on;
  bit out_stalls_on;
  int cfg_writes;
  int settings_used;

  motor_drive_output_stage_core i_dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .balance_drive      (balance_drive),
    .steer_drive        (steer_drive),
    .stop_request       (stop_request),
    .protect_mode       (protect_mode),
    .ramp_section       (ramp_section),
    .special_section    (special_section),
    .left_count         (left_count),
    .right_count        (right_count),
    .speed_sum          (speed_sum),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .left_forward_duty  (left_forward_duty),
    .left_reverse_duty  (left_reverse_duty),
    .right_forward_duty (right_forward_duty),
    .right_reverse_duty (right_reverse_duty),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Drivers. All inputs change by NBA just after a rising edge; handshakes are
  // sampled straight after the edge, which still sees the pre-edge values.
  // --------------------------------------------------------------------------

  // Offer one tick word. Valid is only lowered when a gap is drawn, so a
  // back-to-back word never sees valid dropped and raised in one step.
  task automatic send_word(input tick_word_t w);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    balance_drive   <= w.balance;
    steer_drive     <= w.steer;
    stop_request    <= w.stop;
    protect_mode    <= w.mode;
    ramp_section    <= w.ramp;
    special_section <= w.special;
    left_count      <= w.lcount;
    right_count     <= w.rcount;
    speed_sum       <= w.sum;
    do @(posedge clk); while (!in_ready);
    model.note_word(w);
  endtask

  // One register write; the caller drops cfg_valid after the last of a batch.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    model.write_reg(idx, value[CFG_DATA_W-1:0]);
    cfg_writes++;
  endtask

  // Sender holds off until every predicted duty word has been seen, then
  // lets the pipeline settle so the block is idle for register writes.
  task automatic drain();
    in_valid <= 1'b0;
    while (model.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register settings per phase: both extremes, reset values, random in-range
  // values and random words that also set the unused upper data bits.
  task automatic load_settings(input int phase);
    int gain;
    int step;
    int dmax;
    int lim;
    case (phase)
      1: begin gain = 255; step = 16383; dmax = 16383; lim = COUNT_MAX; end
      2: begin gain = 0;   step = 0;     dmax = 0;     lim = COUNT_MIN; end
      3: begin gain = 1;   step = 1;     dmax = 16383; lim = 0;         end
      5: begin gain = 30;  step = 5000;  dmax = 9999;  lim = 100;       end
      7: begin
        gain = $urandom_range(0, 255);
        step = $urandom_range(0, 200);
        dmax = $urandom_range(0, 16383);
        lim  = int'($urandom_range(0, 400)) - 200;
      end
      default: begin
        gain = $urandom_range(0, 65535);
        step = $urandom_range(0, 65535);
        dmax = $urandom_range(0, 65535);
        lim  = $urandom_range(0, 65535);
      end
    endcase
    write_reg(REG_BRAKE_GAIN, gain);
    write_reg(REG_SLEW_STEP, step);
    write_reg(REG_DUTY_MAX, dmax);
    write_reg(REG_FAST_WHEEL_LIMIT, lim);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic tick_word_t mk(int bal, int steer, bit stop, logic [1:0] mode,
                                    bit ramp, bit special, int lc, int rc, int sum);
    tick_word_t w;
    w.balance = 17'(bal);
    w.steer   = 14'(steer);
    w.stop    = stop;
    w.mode    = mode;
    w.ramp    = ramp;
    w.special = special;
    w.lcount  = 16'(lc);
    w.rcount  = 16'(rc);
    w.sum     = 17'(sum);
    return w;
  endfunction

  // counts either anywhere or hugging the quartering threshold
  function automatic logic signed [15:0] random_count();
    if ($urandom_range(0, 1) != 0) return 16'($urandom);
    return 16'(int'(model.fast_limit) + int'($urandom_range(0, 4)) - 2);
  endfunction

  function automatic tick_word_t random_word();
    tick_word_t w;
    w.stop    = ($urandom_range(0, 3) == 0);
    w.mode    = 2'($urandom_range(0, 3));
    w.ramp    = 1'($urandom_range(0, 1));
    w.special = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0:       w.balance = 17'($urandom);
      1:       w.balance = 17'(($urandom_range(0, 1) != 0) ? BAL_MAX : BAL_MIN);
      default: w.balance = 17'(int'($urandom_range(0, 24000)) - 12000);
    endcase
    // mostly the usual steering span, now and then the whole 14-bit range
    if ($urandom_range(0, 7) == 0) w.steer = 14'($urandom);
    else w.steer = 14'(int'($urandom_range(0, 16000)) - 8000);
    w.lcount = random_count();
    w.rcount = random_count();
    case ($urandom_range(0, 3))
      0:       w.sum = 17'($urandom);
      1:       w.sum = 17'(($urandom_range(0, 1) != 0) ? BAL_MAX : BAL_MIN);
      default: w.sum = 17'(int'($urandom_range(0, 800)) - 400);
    endcase
    return w;
  endfunction

  // Directed words on reset settings (gain 30, step 5000, max 9999, limit 100)
  task automatic run_directed();
    // zero drive must clear both duties
    send_word(mk(0, 0, 0, MODE_NORMAL, 0, 0, 0, 0, 0));
    // saturation both ways
    send_word(mk(BAL_MAX, 0, 0, MODE_NORMAL, 0, 0, 0, 0, 0));
    send_word(mk(BAL_MIN, 0, 0, MODE_NORMAL, 0, 0, 0, 0, 0));
    send_word(mk(1, 0, 0, MODE_NORMAL, 0, 0, 0, 0, 0));
    send_word(mk(-1, 0, 0, MODE_NORMAL, 0, 0, 0, 0, 0));
    // normal mixing, both normal codes
    send_word(mk(3000, 1000, 0, MODE_NORMAL, 0, 0, 0, 0, 0));
    send_word(mk(100, -8000, 0, MODE_NORMAL_ALT, 0, 0, 0, 0, 0));
    send_word(mk(BAL_MIN, STEER_MAX, 0, MODE_NORMAL_ALT, 0, 0, 0, 0, 0));
    // balance only, steering only
    send_word(mk(1234, 500, 0, MODE_BALANCE_ONLY, 0, 0, 0, 0, 0));
    send_word(mk(0, STEER_MAX, 0, MODE_STEER_ONLY, 0, 0, 0, 0, 0));
    send_word(mk(BAL_MAX, STEER_MIN, 0, MODE_STEER_ONLY, 0, 0, 0, 0, 0));
    // brake overrides protect mode, at both ends of speed sum and at zero
    send_word(mk(5000, 3000, 1, MODE_STEER_ONLY, 0, 0, 0, 0, BAL_MAX));
    send_word(mk(-5000, 0, 1, MODE_BALANCE_ONLY, 0, 0, 0, 0, BAL_MIN));
    send_word(mk(0, 0, 1, MODE_NORMAL, 0, 0, 0, 0, 100));
    send_word(mk(7000, 0, 1, MODE_NORMAL, 0, 0, 0, 0, 0));
    // ramp: count just above and at the limit, then far ends of the counts
    send_word(mk(4000, 0, 0, MODE_NORMAL, 1, 0, 101, 100, 0));
    send_word(mk(-7, 0, 0, MODE_NORMAL, 1, 0, COUNT_MAX, COUNT_MAX, 0));
    send_word(mk(BAL_MAX, 0, 0, MODE_NORMAL, 1, 0, COUNT_MIN, COUNT_MAX, 0));
    // special section slew from a full drive to the other extreme and to zero
    send_word(mk(BAL_MAX, 0, 0, MODE_NORMAL, 0, 1, 0, 0, 0));
    send_word(mk(BAL_MIN, 0, 0, MODE_NORMAL, 0, 1, 0, 0, 0));
    send_word(mk(BAL_MIN, 0, 0, MODE_NORMAL, 0, 1, 0, 0, 0));
    send_word(mk(0, 0, 0, MODE_NORMAL, 0, 1, 0, 0, 0));
    send_word(mk(0, 0, 0, MODE_NORMAL, 1, 1, COUNT_MAX, COUNT_MIN, 0));
  endtask

  // --------------------------------------------------------------------------
  // Result side: draw a stall per word, then take and check it.
  // --------------------------------------------------------------------------
  initial begin
    int         stall;
    duty_word_t got;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = out_stalls_on ? $urandom_range(0, MAX_GAP) : 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got = {left_forward_duty, left_reverse_duty, right_forward_duty, right_reverse_duty};
      model.check_duties(got);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long with no word moving on any channel ends the run.
  // --------------------------------------------------------------------------
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout after %0d quiet cycles", WATCHDOG_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst             <= 1'b1;
    in_valid        <= 1'b0;
    balance_drive   <= '0;
    steer_drive     <= '0;
    stop_request    <= 1'b0;
    protect_mode    <= MODE_NORMAL;
    ramp_section    <= 1'b0;
    special_section <= 1'b0;
    left_count      <= '0;
    right_count     <= '0;
    speed_sum       <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= REG_BRAKE_GAIN;
    cfg_data        <= '0;
    in_gaps_on      = 1'b1;
    out_stalls_on   = 1'b1;
    cfg_writes      = 0;
    settings_used   = 1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    drain();

    for (int p = 1; p < NUM_PHASES; p++) begin
      load_settings(p);
      // rotate idling: both, none, sender only, receiver only
      in_gaps_on    = (p % 4 == 0) || (p % 4 == 2);
      out_stalls_on = (p % 4 == 0) || (p % 4 == 3);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) send_word(random_word());
      drain();
    end

    if (model.pending() != 0) begin
      model.errors++;
      $display("%0d predicted duty words never arrived", model.pending());
    end
    $display("ran %0d tick words, checked %0d duty words",
             model.words_noted, model.results_checked);
    $display("%0d register writes over %0d settings", cfg_writes, settings_used);
    $display("mixing modes, brake, ramp quartering, slew and duty limits");
    $display("incl. zero and full scale; %0d errors", model.errors);
    if (model.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
